// ===== hw/rtl/hevc_nal_unit_segmenter_defines.svh =====
// Assertion helpers for the NAL unit segmenter.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef HEVC_NAL_UNIT_SEGMENTER_DEFINES_SVH
`define HEVC_NAL_UNIT_SEGMENTER_DEFINES_SVH

// Implication checked in the same cycle.
`define HNUS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Invariant that holds on every clock edge.
`define HNUS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/hnus_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hnus_pkg;

    localparam int ADDR_BITS_DEFAULT  = 32;
    localparam int COUNT_BITS_DEFAULT = 16;

    // Fixed widths of the result fields
    localparam int ADDR_FIELD_W  = 32;
    localparam int COUNT_FIELD_W = 16;

    // Three bytes before the current one; 00 00 01 there means the current
    // byte is the first header byte.
    localparam int              WINDOW_W     = 24;
    localparam logic [23:0]     START_PREFIX = 24'h000001;
    localparam logic [7:0]      HDR1_ERR_MASK = 8'h81;
    localparam logic [7:0]      HDR2_ERR_MASK = 8'hf8;
    localparam logic [5:0]      TYPE_VPS       = 6'd32;
    localparam logic [5:0]      TYPE_SLICE_MAX = 6'd9;
    localparam int              VPS_BACKOFF   = 4;
    localparam int              SLICE_BACKOFF = 3;

    // Record kinds
    localparam logic [1:0] KIND_UNIT  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic FRAME_INTRA     = 1'b0;
    localparam logic FRAME_PREDICTED = 1'b1;

    // Record queue; depth must be a power of two, at least 2
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                 record_kind;
        logic [1:0]                 region;
        logic [COUNT_FIELD_W-1:0]   unit_index;
        logic [ADDR_FIELD_W-1:0]    start_address;
        logic [ADDR_FIELD_W-1:0]    unit_size;
        logic                       frame_kind;
        logic [COUNT_FIELD_W-1:0]   vps_total;
        logic [COUNT_FIELD_W-1:0]   slice_total;
        logic                       last_of_run;
        logic                       stream_done;
    } out_item_t;

    // Up to two records pushed per accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } q_wr_t;

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
        logic                   empty;
        logic                   room;   // space for two records
    } q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hnus_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnus_front import hnus_pkg::*; #(
    parameter int ADDR_BITS  = ADDR_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire q_stat_t  q_stat,
    output q_wr_t         q_wr
);

    logic [WINDOW_W-1:0]   win_reg,        win_next;
    logic [ADDR_BITS-1:0]  pos_reg,        pos_next;
    logic                  pend_reg,       pend_next;
    logic [7:0]            hdr_byte_reg,   hdr_byte_next;
    logic [ADDR_BITS-1:0]  hdr_pos_reg,    hdr_pos_next;
    logic [ADDR_BITS-1:0]  open_addr_reg,  open_addr_next;
    logic                  open_kind_reg,  open_kind_next;
    logic                  open_valid_reg, open_valid_next;
    logic [COUNT_BITS-1:0] unit_cnt_reg,   unit_cnt_next;
    logic [COUNT_BITS-1:0] vps_cnt_reg,    vps_cnt_next;
    logic [COUNT_BITS-1:0] slice_cnt_reg,  slice_cnt_next;
    logic                  aborted_reg,    aborted_next;

    logic                  accept;
    logic [7:0]            byte_in;
    logic                  eos;
    logic                  match;
    logic                  chk_en;
    logic [7:0]            chk_hb;
    logic [7:0]            chk_b2;
    logic [ADDR_BITS-1:0]  chk_pos;
    logic                  hdr_err;
    logic [5:0]            nal_type;
    logic                  is_vps;
    logic                  is_slice;
    logic                  opens;
    logic [ADDR_BITS-1:0]  vps_addr;
    logic [ADDR_BITS-1:0]  slice_addr;
    logic [ADDR_BITS-1:0]  new_addr;
    logic [ADDR_BITS-1:0]  fin_addr;
    logic                  fin_kind;
    logic                  fin_valid;
    logic [COUNT_BITS-1:0] fin_idx;
    logic [COUNT_BITS-1:0] vps_after;
    logic [COUNT_BITS-1:0] slice_after;
    logic                  rec_a_valid;
    logic                  rec_b_valid;
    out_item_t             rec_a;
    out_item_t             rec_b;

    assign accept  = s_valid & s_ready;
    assign s_ready = q_stat.room;
    assign byte_in = s_data.data_byte;
    assign eos     = s_data.end_of_stream;

    // Header check: either the pending header meets its second byte, or a
    // header byte lands on the last byte and its second byte reads as zero.
    // The two cannot coincide.
    always_comb begin
        match    = (win_reg == START_PREFIX);
        chk_en   = pend_reg | (match & eos);
        chk_hb   = pend_reg ? hdr_byte_reg : byte_in;
        chk_b2   = pend_reg ? byte_in : 8'h00;
        chk_pos  = pend_reg ? hdr_pos_reg : pos_reg;
        hdr_err  = chk_en & ((|(chk_hb & HDR1_ERR_MASK)) | (|(chk_b2 & HDR2_ERR_MASK)));
        nal_type = chk_hb[6:1];
        is_vps   = chk_en & ~hdr_err & (nal_type == TYPE_VPS);
        is_slice = chk_en & ~hdr_err & (nal_type <= TYPE_SLICE_MAX);
        opens    = is_vps | is_slice;

        vps_addr   = (chk_pos >= ADDR_BITS'(VPS_BACKOFF))
                   ? chk_pos - ADDR_BITS'(VPS_BACKOFF) : '0;
        slice_addr = (chk_pos >= ADDR_BITS'(SLICE_BACKOFF))
                   ? chk_pos - ADDR_BITS'(SLICE_BACKOFF) : '0;
        new_addr   = is_vps ? vps_addr : slice_addr;

        vps_after   = vps_cnt_reg + COUNT_BITS'(is_vps);
        slice_after = slice_cnt_reg + COUNT_BITS'(is_slice);

        fin_valid = opens | open_valid_reg;
        fin_addr  = opens ? new_addr : open_addr_reg;
        fin_kind  = opens ? is_slice : open_kind_reg;
        fin_idx   = opens ? unit_cnt_reg : unit_cnt_reg - COUNT_BITS'(1);
    end

    // First record: header error, or the unit closed by the new one
    always_comb begin
        rec_a_valid = hdr_err | (opens & open_valid_reg);
        rec_a       = '0;
        if (hdr_err) begin
            rec_a.record_kind = KIND_ERROR;
            rec_a.vps_total   = COUNT_FIELD_W'(vps_cnt_reg);
            rec_a.slice_total = COUNT_FIELD_W'(slice_cnt_reg);
            rec_a.stream_done = 1'b1;
        end else begin
            rec_a.record_kind   = KIND_UNIT;
            rec_a.unit_index    = COUNT_FIELD_W'(unit_cnt_reg - COUNT_BITS'(1));
            rec_a.start_address = ADDR_FIELD_W'(open_addr_reg);
            rec_a.unit_size     = ADDR_FIELD_W'(new_addr - open_addr_reg);
            rec_a.frame_kind    = open_kind_reg;
        end

        // Second record: end of stream closes the last unit, or reports an empty stream
        rec_b_valid       = eos & ~hdr_err;
        rec_b             = '0;
        rec_b.stream_done = 1'b1;
        rec_b.last_of_run = 1'b1;
        rec_b.vps_total   = COUNT_FIELD_W'(vps_after);
        rec_b.slice_total = COUNT_FIELD_W'(slice_after);
        if (fin_valid) begin
            rec_b.record_kind   = KIND_UNIT;
            rec_b.unit_index    = COUNT_FIELD_W'(fin_idx);
            rec_b.start_address = ADDR_FIELD_W'(fin_addr);
            rec_b.unit_size     = ADDR_FIELD_W'(pos_reg + ADDR_BITS'(1) - fin_addr);
            rec_b.frame_kind    = fin_kind;
        end else begin
            rec_b.record_kind = KIND_EMPTY;
        end
        rec_a.last_of_run = ~rec_b_valid;
    end

    always_comb begin
        q_wr = '0;
        if (accept && !aborted_reg) begin
            q_wr.count  = 2'(rec_a_valid) + 2'(rec_b_valid);
            q_wr.first  = rec_a_valid ? rec_a : rec_b;
            q_wr.second = rec_b;
        end
    end

    always_comb begin
        win_next        = win_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        hdr_byte_next   = hdr_byte_reg;
        hdr_pos_next    = hdr_pos_reg;
        open_addr_next  = open_addr_reg;
        open_kind_next  = open_kind_reg;
        open_valid_next = open_valid_reg;
        unit_cnt_next   = unit_cnt_reg;
        vps_cnt_next    = vps_cnt_reg;
        slice_cnt_next  = slice_cnt_reg;
        aborted_next    = aborted_reg;
        if (accept) begin
            if (eos) begin
                // stream ends: back to the reset state
                win_next        = '1;
                pos_next        = '0;
                pend_next       = 1'b0;
                hdr_byte_next   = '0;
                hdr_pos_next    = '0;
                open_addr_next  = '0;
                open_kind_next  = 1'b0;
                open_valid_next = 1'b0;
                unit_cnt_next   = '0;
                vps_cnt_next    = '0;
                slice_cnt_next  = '0;
                aborted_next    = 1'b0;
            end else if (!aborted_reg) begin
                win_next  = {win_reg[WINDOW_W-9:0], byte_in};
                pos_next  = pos_reg + ADDR_BITS'(1);
                pend_next = match;
                if (match) begin
                    hdr_byte_next = byte_in;
                    hdr_pos_next  = pos_reg;
                end
                if (opens) begin
                    open_addr_next  = new_addr;
                    open_kind_next  = is_slice;
                    open_valid_next = 1'b1;
                    unit_cnt_next   = unit_cnt_reg + COUNT_BITS'(1);
                end
                vps_cnt_next   = vps_after;
                slice_cnt_next = slice_after;
                aborted_next   = hdr_err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg        <= '1;
            pos_reg        <= '0;
            pend_reg       <= 1'b0;
            hdr_byte_reg   <= '0;
            hdr_pos_reg    <= '0;
            open_addr_reg  <= '0;
            open_kind_reg  <= 1'b0;
            open_valid_reg <= 1'b0;
            unit_cnt_reg   <= '0;
            vps_cnt_reg    <= '0;
            slice_cnt_reg  <= '0;
            aborted_reg    <= 1'b0;
        end else begin
            win_reg        <= win_next;
            pos_reg        <= pos_next;
            pend_reg       <= pend_next;
            hdr_byte_reg   <= hdr_byte_next;
            hdr_pos_reg    <= hdr_pos_next;
            open_addr_reg  <= open_addr_next;
            open_kind_reg  <= open_kind_next;
            open_valid_reg <= open_valid_next;
            unit_cnt_reg   <= unit_cnt_next;
            vps_cnt_reg    <= vps_cnt_next;
            slice_cnt_reg  <= slice_cnt_next;
            aborted_reg    <= aborted_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hnus_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnus_queue import hnus_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire q_wr_t q_wr,
    input  wire logic  pop,
    output out_item_t  head,
    output q_stat_t    q_stat
);

    out_item_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg,  count_next;

    // pointers wrap naturally since the depth is a power of two
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(q_wr.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(q_wr.count) - QUEUE_CNT_W'(pop);
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.count = count_reg;
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.room  = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (q_wr.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= q_wr.first;
        end
        if (q_wr.count == 2'd2) begin
            entry_reg[wr_ptr_reg + QUEUE_PTR_W'(1)] <= q_wr.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hnus_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hnus_back import hnus_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data,
    input  wire out_item_t  head,
    input  wire q_stat_t    q_stat,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    logic [1:0] region_reg, region_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;

    assign cfg_ready = 1'b1;

    // refill the output register whenever it is empty or being drained
    always_comb begin
        pop          = ~q_stat.empty & (~m_valid_reg | m_ready);
        region_next  = (cfg_valid & cfg_ready) ? cfg_data : region_reg;
        m_valid_next = pop | (m_valid_reg & ~m_ready);
        m_data_next  = head;
        m_data_next.region = region_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            region_reg  <= region_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hevc_nal_unit_segmenter.sv =====
// HEVC Annex-B NAL unit segmenter.
// s_ channel: one stream byte per transaction (data_byte, end_of_stream on the
// last byte). m_ channel: unit records, a header-error record or an empty-
// stream record; one byte yields zero, one or two records, last_of_run marks
// the final one and stream_done the final record of a stream.
// cfg channel: 2-bit region tag, copied into every record; write it only
// while the block is idle. cfg_ready is always high.
// Throughput: one byte per cycle. The front scanner classifies each byte
// combinationally and pushes its records into a 4-entry queue; it takes a
// byte whenever the queue has room for two records. The back stage drains
// one record per cycle into the output register while m_ready allows; the
// queue absorbs the second record of a two-record byte. Records pass from
// the queue into the output register, which drives m_valid and m_data.
// When m_ready is low the output register holds, the queue fills, and
// s_ready drops once fewer than two entries are free.
// Reset (aresetn low, synchronous) empties the queue and output register,
// clears the region tag and returns the scanner to the start of a stream.
`timescale 1ns / 1ps
`default_nettype none

`include "hevc_nal_unit_segmenter_defines.svh"

module hevc_nal_unit_segmenter import hnus_pkg::*; #(
    parameter int ADDR_BITS  = ADDR_BITS_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data
);

    q_wr_t     q_wr;
    q_stat_t   q_stat;
    out_item_t q_head;
    logic      q_pop;

    hnus_front #(
        .ADDR_BITS  (ADDR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_wr    (q_wr)
    );

    hnus_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (q_pop),
        .head    (q_head),
        .q_stat  (q_stat)
    );

    hnus_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `HNUS_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= QUEUE_CNT_W'(QUEUE_DEPTH), "record queue overflow")
    `HNUS_ASSERT_IMPL(a_push_on_accept, q_wr.count != 2'd0, s_valid && s_ready, "records pushed without an input transaction")
    `HNUS_ASSERT_IMPL(a_done_is_last, m_valid && m_data.stream_done, m_data.last_of_run, "stream_done record not last of run")
    `HNUS_ASSERT_IMPL(a_error_ends_stream, m_valid && m_data.record_kind == KIND_ERROR, m_data.stream_done && m_data.unit_size == '0, "malformed error record")

endmodule

`default_nettype wire
